// ----- design/fird_pkg.sv -----
// fird_pkg: widths, constants, register indexes and control types
// shared by the frame interval rate detector modules; no dependencies
package fird_pkg;

	localparam int FRAMES_W   = 14;
	localparam int EXP_W      = 16;
	localparam int IVAL_W     = 8;
	localparam int AVG_W      = 30;
	localparam int STAB_W     = 3;
	localparam int RATIO_W    = 24;
	localparam int QUO_W      = 34;
	localparam int HALF_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int QUO_BITS_PER_CYCLE = 2;
	localparam int DIV_STEPS          = QUO_W / QUO_BITS_PER_CYCLE;
	localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

	localparam int unsigned STABLE_RUNS_DEF = 6;

	localparam logic [AVG_W-1:0]   AVG_MAX      = {AVG_W{1'b1}};
	localparam logic [RATIO_W-1:0] RATIO_MAX    = {RATIO_W{1'b1}};
	localparam logic [RATIO_W-1:0] LOW_LIMIT    = 24'd68813;
	localparam logic [RATIO_W-1:0] REM_LIMIT    = 24'd3276;
	localparam logic [RATIO_W:0]   ROUND_HALF   = 25'd32768;
	localparam logic [EXP_W-1:0]   EXP_RESET    = 16'd11760;
	localparam logic [HALF_W-1:0]  RECIP_THREE  = 32'hAAAAAAAB;
	localparam logic [EXP_W-1:0]   DIVISOR_ONE  = 16'd1;
	localparam logic [IVAL_W-1:0]  IVAL_ONE     = 8'd1;
	localparam logic [IVAL_W-1:0]  IVAL_MAX     = 8'd255;
	localparam logic [STAB_W-1:0]  STAB_MAX     = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SAMPLES = 2'd1;

	typedef struct packed {
		logic capture;
		logic prep;
		logic step;
		logic map;
		logic commit;
	} fird_cmd_t;

	typedef struct packed {
		logic item_active;
	} fird_sts_t;

endpackage

// ----- design/frame_interval_rate_detector_unit.sv -----
// frame_interval_rate_detector_unit: top level of the frame interval rate detector
// instantiates fird_ctrl and fird_dp; depends on fird_pkg
//
// channel   signals                                  direction
// in        in_valid, in_ready, frames_uploaded      request in
// out       out_valid, out_ready, swap_interval,     request out
//           update_request
// cfg       cfg_valid, cfg_ready, cfg_index,         register write in
//           cfg_data
//
// an active request runs from accept to result through the accept state, a setup
// state that forms the average by a multiply with one third, the two-bit-per-cycle
// divider steps for the ratio, a mapping state and the commit state; in_ready
// returns the cycle after commit. a disabled or zero-count request goes from the
// accept state straight to the commit state.
// reset returns config and detector state to defaults at once. a held result stalls only
// the commit cycle; the next request is accepted while the result waits.
module frame_interval_rate_detector_unit #(
	parameter int unsigned STABLE_RUNS = fird_pkg::STABLE_RUNS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fird_pkg::FRAMES_W-1:0]     frames_uploaded,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fird_pkg::IVAL_W-1:0]       swap_interval,
	output logic                              update_request,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fird_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fird_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fird_pkg::*;

	fird_cmd_t cmd;
	fird_sts_t sts;

	assign cfg_ready = 1'b1;

	fird_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fird_dp #(
		.STABLE_RUNS (STABLE_RUNS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.frames_uploaded (frames_uploaded),
		.cmd             (cmd),
		.sts             (sts),
		.swap_interval   (swap_interval),
		.update_request  (update_request)
	);

endmodule

// ----- design/fird_ctrl.sv -----
// fird_ctrl: sequencer for the rate detector, drives the datapath commands
// depends on fird_pkg
module fird_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fird_pkg::fird_sts_t sts,
	output fird_pkg::fird_cmd_t cmd
);
	import fird_pkg::*;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
	localparam logic [ST_W-1:0] ST_PREP = 3'd2;
	localparam logic [ST_W-1:0] ST_RAT  = 3'd3;
	localparam logic [ST_W-1:0] ST_MAP  = 3'd4;
	localparam logic [ST_W-1:0] ST_FIN  = 3'd5;

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	logic [ST_W-1:0]      state_q, state_n;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_n;
	logic                 out_valid_q;
	logic                 accept;
	logic                 commit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign commit    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					cnt_n       = '0;
					state_n     = sts.item_active ? ST_PREP : ST_FIN;
				end
			end
			ST_RAT: begin
				cmd.step = 1'b1;
				cnt_n    = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					cnt_n   = '0;
					state_n = ST_MAP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_n  = ST_RAT;
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_n = ST_FIN;
			end
			ST_FIN: begin
				if (commit) begin
					cmd.commit = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/fird_dp.sv -----
// fird_dp: config registers, leaky average by reciprocal multiply, radix-4 restoring
// divider for the ratio, interval mapping and stability state; depends on fird_pkg
module fird_dp #(
	parameter int unsigned STABLE_RUNS = fird_pkg::STABLE_RUNS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [fird_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fird_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [fird_pkg::FRAMES_W-1:0]        frames_uploaded,
	input  fird_pkg::fird_cmd_t                  cmd,
	output fird_pkg::fird_sts_t                  sts,
	output logic [fird_pkg::IVAL_W-1:0]          swap_interval,
	output logic                                 update_request
);
	import fird_pkg::*;

	localparam logic [STAB_W-1:0] RUNS = STAB_W'(STABLE_RUNS);

	logic                 detect_enable_q;
	logic [EXP_W-1:0]     expected_samples_q;
	logic [AVG_W-1:0]     rate_average_q;
	logic [IVAL_W-1:0]    candidate_q;
	logic [STAB_W-1:0]    stable_q;
	logic [IVAL_W-1:0]    active_q;

	logic                 skip_q;
	logic [EXP_W-1:0]     div_q;
	logic [EXP_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [IVAL_W-1:0]    ival_q;
	logic                 ival_ok_q;
	logic [IVAL_W-1:0]    swap_interval_q;
	logic                 update_request_q;

	logic [QUO_W-2:0]     acc;
	logic [2*HALF_W-1:0]  prod;
	logic [AVG_W:0]       avg_quo;
	logic [EXP_W:0]       sh1, sh2;
	logic                 ge1, ge2;
	logic [EXP_W-1:0]     rem1, rem2;
	logic [QUO_W-1:0]     q1, q2;
	logic [AVG_W-1:0]     avg_new;
	logic [RATIO_W-1:0]   ratio;
	logic [RATIO_W:0]     rsum;
	logic [IVAL_W-1:0]    ival_c;
	logic [RATIO_W-1:0]   whole;
	logic [RATIO_W-1:0]   rem_c;
	logic                 ok_c;
	logic [STAB_W-1:0]    stab_inc;
	logic [STAB_W-1:0]    stab_n;
	logic [IVAL_W-1:0]    active_n;
	logic [IVAL_W-1:0]    cand_n;
	logic                 req_n;

	assign sts.item_active = detect_enable_q && (frames_uploaded != '0);
	assign swap_interval   = swap_interval_q;
	assign update_request  = update_request_q;

	// n*65536 + 5*avg + 3
	assign acc = {3'b000, frames_uploaded, 16'h0000}
		+ {1'b0, rate_average_q, 2'b00}
		+ {3'b000, rate_average_q}
		+ 33'd3;

	// halved sum times 1/3 gives sum/6
	assign prod    = (2*HALF_W)'(quo_q[HALF_W-1:0]) * (2*HALF_W)'(RECIP_THREE);
	assign avg_quo = prod[2*HALF_W-1:HALF_W+1];

	// two quotient bits per cycle
	always_comb begin
		sh1  = {rem_q, quo_q[QUO_W-1]};
		ge1  = sh1 >= {1'b0, div_q};
		rem1 = ge1 ? EXP_W'(sh1 - {1'b0, div_q}) : sh1[EXP_W-1:0];
		q1   = {quo_q[QUO_W-2:0], ge1};
		sh2  = {rem1, q1[QUO_W-1]};
		ge2  = sh2 >= {1'b0, div_q};
		rem2 = ge2 ? EXP_W'(sh2 - {1'b0, div_q}) : sh2[EXP_W-1:0];
		q2   = {q1[QUO_W-2:0], ge2};
	end

	assign avg_new = avg_quo[AVG_W] ? AVG_MAX : avg_quo[AVG_W-1:0];
	assign ratio   = (quo_q > QUO_W'(RATIO_MAX)) ? RATIO_MAX : quo_q[RATIO_W-1:0];

	// nearest whole interval and its distance
	always_comb begin
		rsum  = {1'b0, ratio} + ROUND_HALF;
		ival_c = rsum[RATIO_W] ? IVAL_MAX : rsum[RATIO_W-1:16];
		whole = {ival_c, 16'h0000};
		rem_c = (ratio >= whole) ? (ratio - whole) : (whole - ratio);
		ok_c  = rem_c <= REM_LIMIT;
		if (ratio < LOW_LIMIT) begin
			ival_c = IVAL_ONE;
			ok_c   = 1'b1;
		end
	end

	// stability update
	always_comb begin
		stab_inc = (stable_q == STAB_MAX) ? STAB_MAX : stable_q + 1'b1;
		stab_n   = '0;
		active_n = active_q;
		cand_n   = candidate_q;
		req_n    = 1'b0;
		if (ival_ok_q && (ival_q != active_q)) begin
			stab_n = (ival_q == candidate_q) ? stab_inc : '0;
			if (stab_n >= RUNS) begin
				active_n = ival_q;
				stab_n   = '0;
				req_n    = 1'b1;
			end
			cand_n = ival_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_enable_q    <= 1'b0;
			expected_samples_q <= EXP_RESET;
			rate_average_q     <= '0;
			candidate_q        <= IVAL_ONE;
			stable_q           <= '0;
			active_q           <= IVAL_ONE;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_DETECT_ENABLE:    detect_enable_q    <= cfg_data[0];
					CFG_EXPECTED_SAMPLES: expected_samples_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.prep) begin
				rate_average_q <= avg_new;
			end
			if (cmd.commit && !skip_q) begin
				candidate_q <= cand_n;
				stable_q    <= stab_n;
				active_q    <= active_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			skip_q <= !sts.item_active;
			quo_q  <= QUO_W'(acc[QUO_W-2:1]);
		end else if (cmd.prep) begin
			quo_q <= {avg_new, 4'h0};
			rem_q <= '0;
			div_q <= (expected_samples_q == '0) ? DIVISOR_ONE : expected_samples_q;
		end else if (cmd.step) begin
			quo_q <= q2;
			rem_q <= rem2;
		end
		if (cmd.map) begin
			ival_q    <= ival_c;
			ival_ok_q <= ok_c;
		end
		if (cmd.commit) begin
			swap_interval_q  <= skip_q ? active_q : active_n;
			update_request_q <= skip_q ? 1'b0 : req_n;
		end
	end

endmodule

// ----- design/fird_chk.sv -----
// fird_chk: port-level checks for frame_interval_rate_detector_unit
// bound to the top level below; depends on fird_pkg
module fird_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fird_pkg::IVAL_W-1:0]   swap_interval,
	input logic                          update_request
);
	import fird_pkg::*;

	logic [IVAL_W-1:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= IVAL_ONE;
		end else if (out_valid && out_ready) begin
			last_q <= swap_interval;
		end
	end

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(swap_interval)
			&& $stable(update_request))
		else $error("result changed while stalled");

	// one request in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// interval changes only with an update request
	a_no_req_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !update_request |-> swap_interval == last_q)
		else $error("interval changed without update request");

	a_req_diff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && update_request |-> swap_interval != last_q)
		else $error("update request without interval change");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> swap_interval != '0)
		else $error("zero swap interval");

endmodule

bind frame_interval_rate_detector_unit fird_chk u_fird_chk (.*);

// ----- bench/frame_interval_rate_detector_unit_tb.sv -----
// frame_interval_rate_detector_unit_tb: self-checking bench for the frame interval rate detector
// drives frame counts with random idle gaps and register writes, predicts every swap interval
// depends on fird_pkg and frame_interval_rate_detector_unit
module frame_interval_rate_detector_unit_tb;
	import fird_pkg::*;

	localparam int unsigned RUNS_TO_SWITCH = STABLE_RUNS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_WAIT = 16;
	localparam int FRAMES_MAX = (1 << FRAMES_W) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [IVAL_W-1:0] swap_interval;
		logic              update_request;
	} interval_result_t;

	class swap_interval_predictor;
		logic                detect_on;
		logic [EXP_W-1:0]    frames_per_run;
		logic [AVG_W-1:0]    rate_avg;
		logic [IVAL_W-1:0]   candidate;
		logic [STAB_W-1:0]   stable_runs;
		logic [IVAL_W-1:0]   active;
		interval_result_t    expected_intervals[$];
		int                  mismatches;
		int                  switches;

		function new();
			detect_on = 1'b0;
			frames_per_run = EXP_RESET;
			rate_avg = '0;
			candidate = IVAL_ONE;
			stable_runs = '0;
			active = IVAL_ONE;
			mismatches = 0;
			switches = 0;
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_DETECT_ENABLE) begin
				detect_on = data[0];
			end else if (idx == CFG_EXPECTED_SAMPLES) begin
				frames_per_run = data[EXP_W-1:0];
			end
		endfunction

		function void note_frames(input logic [FRAMES_W-1:0] frames);
			logic [63:0]       acc;
			logic [63:0]       avg;
			logic [63:0]       divisor;
			logic [63:0]       ratio;
			logic [63:0]       rounded;
			logic [63:0]       whole;
			logic [63:0]       remainder;
			logic [IVAL_W-1:0] ival;
			interval_result_t  res;
			res.update_request = 1'b0;
			if (detect_on && frames != '0) begin
				acc = (64'(frames) << 16) + 64'd5 * 64'(rate_avg) + 64'd3;
				avg = acc / 64'd6;
				if (avg > 64'(AVG_MAX)) begin
					avg = 64'(AVG_MAX);
				end
				rate_avg = avg[AVG_W-1:0];
				divisor = (frames_per_run == '0) ? 64'(DIVISOR_ONE) : 64'(frames_per_run);
				ratio = (avg * 64'd16) / divisor;
				if (ratio > 64'(RATIO_MAX)) begin
					ratio = 64'(RATIO_MAX);
				end
				if (ratio < 64'(LOW_LIMIT)) begin
					ival = IVAL_ONE;
					remainder = '0;
				end else begin
					rounded = (ratio + 64'(ROUND_HALF)) >> 16;
					if (rounded > 64'(IVAL_MAX)) begin
						rounded = 64'(IVAL_MAX);
					end
					ival = rounded[IVAL_W-1:0];
					whole = rounded << 16;
					remainder = (ratio >= whole) ? ratio - whole : whole - ratio;
				end
				if (remainder <= 64'(REM_LIMIT) && ival != active) begin
					if (ival == candidate) begin
						stable_runs = (stable_runs == STAB_MAX) ? STAB_MAX : stable_runs + 1'b1;
					end else begin
						stable_runs = '0;
					end
					if (32'(stable_runs) >= RUNS_TO_SWITCH) begin
						active = ival;
						stable_runs = '0;
						res.update_request = 1'b1;
						switches++;
					end
					candidate = ival;
				end else begin
					stable_runs = '0;
				end
			end
			res.swap_interval = active;
			expected_intervals.push_back(res);
		endfunction

		function void check_result(input logic [IVAL_W-1:0] ival, input logic req);
			interval_result_t want;
			if (expected_intervals.size() == 0) begin
				$error("unexpected result: swap_interval %0d update_request %0d", ival, req);
				mismatches++;
				return;
			end
			want = expected_intervals.pop_front();
			if (ival !== want.swap_interval) begin
				$error("swap_interval: expected %0d, actual %0d", want.swap_interval, ival);
				mismatches++;
			end
			if (req !== want.update_request) begin
				$error("update_request: expected %0d, actual %0d", want.update_request, req);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FRAMES_W-1:0]   frames_uploaded = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [IVAL_W-1:0]     swap_interval;
	logic                  update_request;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	swap_interval_predictor interval_calc = new();
	logic [EXP_W-1:0]       cur_expected = EXP_RESET;
	bit                     in_steady = 1'b0;
	bit                     out_steady = 1'b0;
	int                     requests_sent = 0;
	int                     results_seen = 0;
	int                     settings_applied = 0;
	int                     cycle_count = 0;

	frame_interval_rate_detector_unit #(
		.STABLE_RUNS(RUNS_TO_SWITCH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.frames_uploaded(frames_uploaded),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.swap_interval  (swap_interval),
		.update_request (update_request),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int eff_expected();
		return (cur_expected == '0) ? 1 : int'(cur_expected);
	endfunction

	function automatic int frames_for(input int k);
		int v;
		v = (k * eff_expected() + 8) / 16;
		if (v < 1) v = 1;
		if (v > FRAMES_MAX) v = FRAMES_MAX;
		return v;
	endfunction

	// mostly near the target, some right at the 5% tolerance edge, a few zero counts
	function automatic int jittered(input int base);
		int d;
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				d = base / 100;
				n = base + int'($urandom_range(0, 2 * d)) - d;
			end
			6, 7: begin
				d = base / 20 + int'($urandom_range(0, base / 100));
				n = ($urandom_range(0, 1) == 1) ? base + d : base - d;
			end
			8: n = 0;
			default: n = base;
		endcase
		if (n > FRAMES_MAX) n = FRAMES_MAX;
		if (n < 0) n = 0;
		return n;
	endfunction

	task automatic send_frames(input int frames);
		int gap;
		if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
		gap = in_steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		frames_uploaded <= frames[FRAMES_W-1:0];
		do @(posedge clk); while (!in_ready);
		interval_calc.note_frames(frames[FRAMES_W-1:0]);
		requests_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (interval_calc.expected_intervals.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_push(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		interval_calc.set_register(idx, data);
		if (idx == CFG_EXPECTED_SAMPLES) cur_expected = data[EXP_W-1:0];
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] enable_word,
			input logic [CFG_DATA_W-1:0] exp_word, input bit touch_spare);
		drain_results();
		cfg_push(CFG_DETECT_ENABLE, enable_word);
		cfg_push(CFG_EXPECTED_SAMPLES, exp_word);
		if (touch_spare) cfg_push(CFG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// runs of one target interval long enough to settle the average, plus noise bursts
	task automatic drive_random(input int count);
		int made;
		int target;
		int kmax;
		int hold;
		int base;
		made = 0;
		target = 1;
		kmax = (FRAMES_MAX * 16) / eff_expected();
		if (kmax > 255) kmax = 255;
		if (kmax < 1) kmax = 1;
		while (made < count) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 4)) begin
					send_frames($urandom_range(0, FRAMES_MAX));
					made++;
				end
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					target = $urandom_range(1, kmax);
				end else begin
					target = target + int'($urandom_range(0, 4)) - 2;
				end
				if (target < 1) target = 1;
				if (target > kmax) target = kmax;
				hold = $urandom_range(12, 40);
				if (hold > count - made) hold = count - made;
				base = frames_for(target);
				repeat (hold) begin
					send_frames(jittered(base));
					made++;
				end
			end
		end
	endtask

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
			stall = out_steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			interval_calc.check_result(swap_interval, update_request);
			results_seen++;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: detection off, every request passes state through
		send_frames(0);
		send_frames(FRAMES_MAX);
		send_frames(1);
		send_frames(14'h2AAA);
		send_frames(14'h1555);

		// zero expected count acts as one, ratio saturates
		program_regs(16'h0001, 16'd0, 1'b1);
		send_frames(FRAMES_MAX);
		send_frames(FRAMES_MAX);
		send_frames(1);
		send_frames(0);

		program_regs(16'hFFFF, 16'hFFFF, 1'b0);
		send_frames(FRAMES_MAX);
		send_frames(1);
		send_frames(14'h2AAA);
		send_frames(0);
		send_frames(14'h1555);

		program_regs(16'h0001, EXP_RESET, 1'b0);
		drive_random(120);
		program_regs(16'h0001, 16'd64, 1'b0);
		drive_random(100);
		program_regs(16'hFFFE, CFG_DATA_W'($urandom_range(1, 65535)), 1'b0);
		drive_random(20);
		program_regs(16'h0001, 16'hFFFF, 1'b0);
		drive_random(80);
		program_regs(16'h0001, 16'd1, 1'b0);
		drive_random(40);
		repeat (2) begin
			program_regs(16'h0001, CFG_DATA_W'($urandom_range(16, 4000)), 1'b0);
			drive_random(80);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d frame counts over %0d register settings, checked %0d results",
			requests_sent, settings_applied + 1, results_seen);
		$display("saw %0d interval switches, %0d mismatches",
			interval_calc.switches, interval_calc.mismatches);
		if (interval_calc.mismatches == 0 && interval_calc.expected_intervals.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
